// ===== src/slac_pkg.sv =====
// ----------------------------------------------------------------------------
// slac_pkg
// Types, codes and reset constants shared by the link matching sequencer.
// ----------------------------------------------------------------------------
package slac_pkg;

  localparam int unsigned TIME_W = 32;
  localparam int unsigned CFG_W  = 16;
  localparam int unsigned CNT_W  = 8;
  localparam int unsigned IDX_W  = 3;

  // register indexes
  localparam logic [IDX_W-1:0] CFG_PARAM_PERIOD = 3'd0;
  localparam logic [IDX_W-1:0] CFG_OVERALL_TMO  = 3'd1;
  localparam logic [IDX_W-1:0] CFG_SOUND_PAUSE  = 3'd2;
  localparam logic [IDX_W-1:0] CFG_SETTLE_TIME  = 3'd3;
  localparam logic [IDX_W-1:0] CFG_SOUND_COUNT  = 3'd4;

  // register reset values
  localparam logic [CFG_W-1:0] RST_PARAM_PERIOD = 16'd500;
  localparam logic [CFG_W-1:0] RST_OVERALL_TMO  = 16'd10000;
  localparam logic [CFG_W-1:0] RST_SOUND_PAUSE  = 16'd40;
  localparam logic [CFG_W-1:0] RST_SETTLE_TIME  = 16'd100;
  localparam logic [CNT_W-1:0] RST_SOUND_COUNT  = 8'd10;

  // received message codes
  localparam logic [2:0] MSG_SWVER  = 3'd1;
  localparam logic [2:0] MSG_PARAM  = 3'd2;
  localparam logic [2:0] MSG_ATTEN  = 3'd3;
  localparam logic [2:0] MSG_MATCH  = 3'd4;
  localparam logic [2:0] MSG_SETKEY = 3'd5;

  // reported phase codes
  localparam logic [3:0] PC_VERSION     = 4'd0;
  localparam logic [3:0] PC_IDLE        = 4'd1;
  localparam logic [3:0] PC_ESTABLISH   = 4'd2;
  localparam logic [3:0] PC_START_ATTEN = 4'd3;
  localparam logic [3:0] PC_SOUNDING    = 4'd4;
  localparam logic [3:0] PC_ATTEN_CHAR  = 4'd5;
  localparam logic [3:0] PC_MATCH       = 4'd6;
  localparam logic [3:0] PC_SET_KEY     = 4'd7;
  localparam logic [3:0] PC_SETTLE      = 4'd8;
  localparam logic [3:0] PC_FAILED      = 4'd9;
  localparam logic [3:0] PC_MATCHED     = 4'd10;

  typedef enum logic [3:0] {
    ACT_NONE        = 4'd0,
    ACT_SWVER       = 4'd1,
    ACT_CLEAR       = 4'd2,
    ACT_PARAM       = 4'd3,
    ACT_START_ATTEN = 4'd4,
    ACT_SOUND       = 4'd5,
    ACT_ATTEN_RSP   = 4'd6,
    ACT_MATCH       = 4'd7,
    ACT_SETKEY      = 4'd8
  } action_t;

  typedef enum logic [10:0] {
    PH_VERSION     = 11'b000_0000_0001,
    PH_IDLE        = 11'b000_0000_0010,
    PH_ESTABLISH   = 11'b000_0000_0100,
    PH_START_ATTEN = 11'b000_0000_1000,
    PH_SOUNDING    = 11'b000_0001_0000,
    PH_ATTEN_CHAR  = 11'b000_0010_0000,
    PH_MATCH       = 11'b000_0100_0000,
    PH_SET_KEY     = 11'b000_1000_0000,
    PH_SETTLE      = 11'b001_0000_0000,
    PH_FAILED      = 11'b010_0000_0000,
    PH_MATCHED     = 11'b100_0000_0000
  } phase_t;

  typedef struct packed {
    action_t          action;
    logic [CNT_W-1:0] sound_index;
    logic             finished;
    logic [3:0]       phase;
  } result_t;

  // wrap-safe deadline test
  function automatic logic reached(input logic [TIME_W-1:0] now,
                                   input logic [TIME_W-1:0] deadline);
    logic [TIME_W-1:0] diff;
    diff = now - deadline;
    return ~diff[TIME_W-1];
  endfunction

  function automatic logic [3:0] phase_code(input phase_t ph);
    logic [3:0] code;
    case (ph)
      PH_VERSION:     code = PC_VERSION;
      PH_IDLE:        code = PC_IDLE;
      PH_ESTABLISH:   code = PC_ESTABLISH;
      PH_START_ATTEN: code = PC_START_ATTEN;
      PH_SOUNDING:    code = PC_SOUNDING;
      PH_ATTEN_CHAR:  code = PC_ATTEN_CHAR;
      PH_MATCH:       code = PC_MATCH;
      PH_SET_KEY:     code = PC_SET_KEY;
      PH_SETTLE:      code = PC_SETTLE;
      PH_FAILED:      code = PC_FAILED;
      PH_MATCHED:     code = PC_MATCHED;
      default:        code = PC_VERSION;
    endcase
    return code;
  endfunction

endpackage

// ===== src/slac_if.sv =====
// ----------------------------------------------------------------------------
// slac_in_if / slac_out_if
// Valid/ready channels for polling steps and their results.
// ----------------------------------------------------------------------------
interface slac_in_if;
  logic                          valid;
  logic                          ready;
  logic                          start_req;
  logic [2:0]                    rx_message;
  logic [slac_pkg::TIME_W-1:0]   now_ms;

  modport source (output valid, output start_req, output rx_message, output now_ms,
                  input ready);
  modport sink (input valid, input start_req, input rx_message, input now_ms,
                output ready);
endinterface

interface slac_out_if;
  logic                         valid;
  logic                         ready;
  logic [3:0]                   action;
  logic [slac_pkg::CNT_W-1:0]   sound_index;
  logic                         finished;
  logic [3:0]                   phase;

  modport source (output valid, output action, output sound_index, output finished,
                  output phase, input ready);
  modport sink (input valid, input action, input sound_index, input finished,
                input phase, output ready);
endinterface

// ===== src/slac_vehicle_side_sequencer.sv =====
// ----------------------------------------------------------------------------
// slac_vehicle_side_sequencer
// Vehicle-side link matching sequencer, one polling step per transfer.
// ----------------------------------------------------------------------------
// Usage:
//   in_if  : one polling step per transfer (start level, received message
//            code, free-running millisecond time).
//   out_if : one result per step (action, sounds left, finished, phase).
//   cfg_*  : write port for the five timing/count registers; write only
//            while no step is outstanding.
// Output: each result is registered in the output register, or in the skid
//   register while out_if stalls. Throughput: one step per cycle while
//   in_if.ready is high; state updates in the same cycle the step is taken.
// Stall: a two-entry output buffer (output register plus skid register)
//   holds results. in_if.ready drops only while both entries are full, so
//   one more step is taken after out_if stalls.
// Reset: rst_n (synchronous, active low) returns the phase to the version
//   query with the entry flag set, clears all deadlines and the sound count,
//   loads the register defaults and empties the output buffer.
// ----------------------------------------------------------------------------
module slac_vehicle_side_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  slac_in_if.sink                       in_if,
  slac_out_if.source                    out_if,
  input  logic                          cfg_we,
  input  logic [slac_pkg::IDX_W-1:0]    cfg_index,
  input  logic [slac_pkg::CFG_W-1:0]    cfg_wdata
);

  localparam int unsigned TW = slac_pkg::TIME_W;
  localparam int unsigned CW = slac_pkg::CNT_W;

  // configuration registers
  logic [slac_pkg::CFG_W-1:0] period_r, timeout_r, pause_r, settle_r;
  logic [CW-1:0]              count_cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= slac_pkg::RST_PARAM_PERIOD;
      timeout_r   <= slac_pkg::RST_OVERALL_TMO;
      pause_r     <= slac_pkg::RST_SOUND_PAUSE;
      settle_r    <= slac_pkg::RST_SETTLE_TIME;
      count_cfg_r <= slac_pkg::RST_SOUND_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        slac_pkg::CFG_PARAM_PERIOD: period_r    <= cfg_wdata;
        slac_pkg::CFG_OVERALL_TMO:  timeout_r   <= cfg_wdata;
        slac_pkg::CFG_SOUND_PAUSE:  pause_r     <= cfg_wdata;
        slac_pkg::CFG_SETTLE_TIME:  settle_r    <= cfg_wdata;
        slac_pkg::CFG_SOUND_COUNT:  count_cfg_r <= cfg_wdata[CW-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  slac_pkg::phase_t phase_r, phase_nxt;
  logic             just_r, just_nxt;
  logic [TW-1:0]    od_r, od_nxt;
  logic [TW-1:0]    nrt_r, nrt_nxt;
  logic [CW-1:0]    sl_r, sl_nxt;
  logic [TW-1:0]    ps_r, ps_nxt;
  logic [TW-1:0]    sd_r, sd_nxt;

  slac_pkg::action_t act;
  logic [CW-1:0]     sidx;
  logic              active;
  logic              finished;
  logic              in_xfer;
  logic [TW-1:0]     now;
  logic [TW-1:0]     nrt_eff, sd_eff, pause_end;
  logic [CW-1:0]     sl_eff, sl_dec;
  logic              sound_due;

  assign now     = in_if.now_ms;
  assign in_xfer = in_if.valid && in_if.ready;

  assign active = (phase_r == slac_pkg::PH_ESTABLISH) ||
                  (phase_r == slac_pkg::PH_START_ATTEN) ||
                  (phase_r == slac_pkg::PH_SOUNDING) ||
                  (phase_r == slac_pkg::PH_ATTEN_CHAR) ||
                  (phase_r == slac_pkg::PH_MATCH) ||
                  (phase_r == slac_pkg::PH_SET_KEY) ||
                  (phase_r == slac_pkg::PH_SETTLE);
  assign finished = (phase_r == slac_pkg::PH_FAILED) || (phase_r == slac_pkg::PH_MATCHED);

  assign nrt_eff   = just_r ? now : nrt_r;
  assign sd_eff    = just_r ? now + {{(TW - slac_pkg::CFG_W){1'b0}}, settle_r} : sd_r;
  assign pause_end = ps_r + {{(TW - slac_pkg::CFG_W){1'b0}}, pause_r};
  assign sl_eff    = just_r ? ((count_cfg_r == '0) ? CW'(1) : count_cfg_r) : sl_r;
  assign sl_dec    = sl_eff - CW'(1);
  assign sound_due = just_r || ((sl_r != '0) && slac_pkg::reached(now, pause_end));

  always_comb begin
    phase_nxt = phase_r;
    act       = slac_pkg::ACT_NONE;
    sidx      = '0;
    od_nxt    = od_r;
    nrt_nxt   = nrt_r;
    sl_nxt    = sl_r;
    ps_nxt    = ps_r;
    sd_nxt    = sd_r;
    if (active && slac_pkg::reached(now, od_r)) begin
      phase_nxt = slac_pkg::PH_FAILED;
    end else begin
      case (phase_r)
        slac_pkg::PH_VERSION: begin
          if (just_r) act = slac_pkg::ACT_SWVER;
          if (in_if.rx_message == slac_pkg::MSG_SWVER) phase_nxt = slac_pkg::PH_IDLE;
        end
        slac_pkg::PH_IDLE: begin
          if (just_r) act = slac_pkg::ACT_CLEAR;
          if (in_if.start_req) begin
            od_nxt    = now + {{(TW - slac_pkg::CFG_W){1'b0}}, timeout_r};
            phase_nxt = slac_pkg::PH_ESTABLISH;
          end
        end
        slac_pkg::PH_ESTABLISH: begin
          nrt_nxt = nrt_eff;
          if (!in_if.start_req) phase_nxt = slac_pkg::PH_IDLE;
          if (in_if.rx_message == slac_pkg::MSG_PARAM) phase_nxt = slac_pkg::PH_START_ATTEN;
          if (slac_pkg::reached(now, nrt_eff)) begin
            nrt_nxt = now + {{(TW - slac_pkg::CFG_W){1'b0}}, period_r};
            od_nxt  = now + {{(TW - slac_pkg::CFG_W){1'b0}}, timeout_r};
            act     = slac_pkg::ACT_PARAM;
          end
        end
        slac_pkg::PH_START_ATTEN: begin
          act       = slac_pkg::ACT_START_ATTEN;
          phase_nxt = slac_pkg::PH_SOUNDING;
        end
        slac_pkg::PH_SOUNDING: begin
          sl_nxt = sl_eff;
          if (sound_due) begin
            sl_nxt = sl_dec;
            act    = slac_pkg::ACT_SOUND;
            sidx   = sl_dec;
            ps_nxt = now;
          end
          if (sl_nxt == '0) phase_nxt = slac_pkg::PH_ATTEN_CHAR;
        end
        slac_pkg::PH_ATTEN_CHAR: begin
          if (in_if.rx_message == slac_pkg::MSG_ATTEN) begin
            act       = slac_pkg::ACT_ATTEN_RSP;
            phase_nxt = slac_pkg::PH_MATCH;
          end
        end
        slac_pkg::PH_MATCH: begin
          if (just_r) act = slac_pkg::ACT_MATCH;
          if (in_if.rx_message == slac_pkg::MSG_MATCH) phase_nxt = slac_pkg::PH_SET_KEY;
        end
        slac_pkg::PH_SET_KEY: begin
          if (just_r) act = slac_pkg::ACT_SETKEY;
          if (in_if.rx_message == slac_pkg::MSG_SETKEY) phase_nxt = slac_pkg::PH_SETTLE;
        end
        slac_pkg::PH_SETTLE: begin
          sd_nxt = sd_eff;
          if (slac_pkg::reached(now, sd_eff)) phase_nxt = slac_pkg::PH_MATCHED;
        end
        slac_pkg::PH_FAILED, slac_pkg::PH_MATCHED: begin
          if (!in_if.start_req) phase_nxt = slac_pkg::PH_IDLE;
        end
        default: ;
      endcase
    end
  end

  assign just_nxt = (phase_nxt != phase_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= slac_pkg::PH_VERSION;
      just_r  <= 1'b1;
      od_r    <= '0;
      nrt_r   <= '0;
      sl_r    <= '0;
      ps_r    <= '0;
      sd_r    <= '0;
    end else if (in_xfer) begin
      phase_r <= phase_nxt;
      just_r  <= just_nxt;
      od_r    <= od_nxt;
      nrt_r   <= nrt_nxt;
      sl_r    <= sl_nxt;
      ps_r    <= ps_nxt;
      sd_r    <= sd_nxt;
    end
  end

  // output register plus skid register
  slac_pkg::result_t res, out_r, skid_r;
  logic              out_vld_r, skid_vld_r;
  logic              pop;

  assign res.action      = act;
  assign res.sound_index = sidx;
  assign res.finished    = finished;
  assign res.phase       = slac_pkg::phase_code(phase_nxt);

  assign pop         = out_vld_r && out_if.ready;
  assign in_if.ready = ~skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (pop) begin
      if (skid_vld_r) begin
        out_r      <= skid_r;
        skid_vld_r <= in_xfer;
        if (in_xfer) skid_r <= res;
      end else begin
        out_vld_r <= in_xfer;
        out_r     <= res;
      end
    end else if (!out_vld_r) begin
      out_vld_r <= in_xfer;
      out_r     <= res;
    end else if (in_xfer) begin
      skid_r     <= res;
      skid_vld_r <= 1'b1;
    end
  end

  assign out_if.valid       = out_vld_r;
  assign out_if.action      = out_r.action;
  assign out_if.sound_index = out_r.sound_index;
  assign out_if.finished    = out_r.finished;
  assign out_if.phase       = out_r.phase;

endmodule

// ===== src/slac_checker.sv =====
// ----------------------------------------------------------------------------
// slac_checker
// Port-level checks on the link matching sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module slac_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [3:0]                  out_action,
  input logic [slac_pkg::CNT_W-1:0]  out_sound_index,
  input logic                        out_finished,
  input logic [3:0]                  out_phase
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) &&
    $stable(out_sound_index) && $stable(out_finished) && $stable(out_phase))
    else $error("stalled result changed");

  // input back-pressure only with a result pending
  a_ready_buf: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !$past(out_ready))
    else $error("input stalled without a pending result");

  // sound count only rides on a sound action
  a_sidx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action != slac_pkg::ACT_SOUND) |-> out_sound_index == '0)
    else $error("sound index without sound action");

  // failed phase never carries an action
  a_fail_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_phase == slac_pkg::PC_FAILED) |-> out_action == slac_pkg::ACT_NONE)
    else $error("action issued in failed phase");

  // empty buffer after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("buffer not empty after reset");

endmodule

bind slac_vehicle_side_sequencer slac_checker u_slac_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_action      (out_if.action),
  .out_sound_index (out_if.sound_index),
  .out_finished    (out_if.finished),
  .out_phase       (out_if.phase)
);
